// ===== hdl/swlr_pkg.sv =====
// Package for the sliding-window link receiver.
// Holds framing characters, request codes, parser phase codes and ring sizes; no dependencies.
package swlr_pkg;

    localparam logic [7:0] CH_DATA_OPEN  = 8'h7B;
    localparam logic [7:0] CH_DATA_CLOSE = 8'h7D;
    localparam logic [7:0] CH_ACK_OPEN   = 8'h3C;
    localparam logic [7:0] CH_ACK_CLOSE  = 8'h3E;
    localparam logic [7:0] CH_ESC        = 8'h5C;

    localparam logic [1:0] REQ_BYTE    = 2'd0;
    localparam logic [1:0] REQ_SENT    = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;

    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_SEQ  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    localparam logic [4:0] EARLY_MAX = 5'd31;

    // Ring and window sizes, fixed by the 4-bit slot and 5-bit count fields.
    localparam int RX_SLOTS   = 16;
    localparam int WINDOW_MAX = 16;

endpackage

// ===== hdl/swlr_if.sv =====
// Valid/ready channel interfaces for the link receiver items.
// Independent of the package; payload widths are those of the item fields.
interface swlr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] rx_byte;
    logic [3:0] release_slot;
    modport source (output valid, req_type, rx_byte, release_slot, input ready);
    modport sink   (input valid, req_type, rx_byte, release_slot, output ready);
endinterface

interface swlr_out_if;
    logic       valid;
    logic       ready;
    logic       payload_write;
    logic [3:0] payload_slot;
    logic [7:0] payload_offset;
    logic [7:0] payload_byte;
    logic       slot_overflow;
    logic       ack_send;
    logic [7:0] ack_seq;
    logic       tx_accepted;
    logic [7:0] tx_seq;
    logic [4:0] tx_in_flight;
    logic [7:0] tx_base_seq;
    logic [3:0] rx_tail_slot;
    modport source (output valid, payload_write, payload_slot, payload_offset, payload_byte,
                    slot_overflow, ack_send, ack_seq, tx_accepted, tx_seq, tx_in_flight,
                    tx_base_seq, rx_tail_slot, input ready);
    modport sink   (input valid, payload_write, payload_slot, payload_offset, payload_byte,
                    slot_overflow, ack_send, ack_seq, tx_accepted, tx_seq, tx_in_flight,
                    tx_base_seq, rx_tail_slot, output ready);
endinterface

// ===== hdl/sliding_window_link_receiver_unit.sv =====
// Top level of the sliding-window link receiver.
// Depends on swlr_pkg and the channel interfaces in swlr_if.sv.
//
// Each item passes through a read state, which issues the read of the
// slot-length memory, and an execute state, which acts on its registered
// read data; a new slot length is written back in the cycle after that. An
// item that closes a data packet then walks the tail over the receive bitmap,
// one position at a time (at most the window size, so at most 16), and forms
// the ack once the walk ends. The next item is accepted only once the block
// is idle and the output register is empty or is emptied in that same cycle.
module sliding_window_link_receiver_unit
    import swlr_pkg::*;
#(
    parameter int SLOT_BYTES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    swlr_in_if.sink     in_ch,
    swlr_out_if.source  out_ch
);

    localparam int SW = (RX_SLOTS > 1) ? $clog2(RX_SLOTS) : 1;
    localparam int LW = $clog2(SLOT_BYTES + 1);
    localparam int MW = 32;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;
    localparam logic [1:0] ST_TAIL = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [4:0]  win_reg;
    logic [1:0]  phase_reg;
    logic        in_ack_reg, esc_reg;
    logic [7:0]  cur_seq_reg, rx_base_reg, tx_old_reg;
    logic [MW-1:0] map_reg;
    logic [SW-1:0] tail_reg;
    logic [4:0]  tx_out_reg, early_reg;
    logic [1:0]  req_reg;
    logic [7:0]  byte_reg;
    logic [3:0]  rel_reg;

    // Output register.
    logic        ov_reg;
    logic        o_pw, o_ovf, o_ack, o_txa;
    logic [3:0]  o_slot;
    logic [7:0]  o_off, o_byte, o_ackseq, o_txseq;

    // Slot-length memory; an entry not yet written since reset reads as zero.
    logic [LW-1:0] len_mem [RX_SLOTS];
    logic [LW-1:0] len_rd;
    logic          len_rd_vld;
    logic [RX_SLOTS-1:0] len_vld_reg;
    logic [LW-1:0] len_cur;
    logic          mem_we;
    logic [SW-1:0] mem_waddr, mem_raddr;
    logic [LW-1:0] mem_wdata;

    logic [4:0] eff_win;
    assign eff_win = (win_reg > 5'(WINDOW_MAX)) ? 5'(WINDOW_MAX) : win_reg;

    // Slot that the current data byte goes to.
    logic [7:0] cur_gap;
    logic [SW-1:0] cur_slot;
    assign cur_gap  = cur_seq_reg - rx_base_reg;
    assign cur_slot = SW'((32'(cur_gap) + 32'(tail_reg)) % RX_SLOTS);

    // Decode of a received byte in the body phase that stores it or closes the packet.
    logic store_req;
    logic close_req;
    always_comb
    begin
        store_req = 1'b0;
        close_req = 1'b0;
        if (req_reg == REQ_BYTE && phase_reg == PH_BODY && !in_ack_reg) begin
            if (esc_reg)
                store_req = (byte_reg == CH_ESC) || (byte_reg == CH_DATA_CLOSE);
            else begin
                store_req = (byte_reg != CH_ESC) && (byte_reg != CH_DATA_CLOSE);
                close_req = (byte_reg == CH_DATA_CLOSE);
            end
        end
    end

    assign in_ch.ready = (state_reg == ST_IDLE) && (!ov_reg || out_ch.ready);
    assign mem_raddr   = cur_slot;
    assign len_cur     = len_rd_vld ? len_rd : '0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            len_mem[mem_waddr] <= mem_wdata;
        len_rd     <= len_mem[mem_raddr];
        len_rd_vld <= len_vld_reg[mem_raddr];
    end

    // Written marks for the slot-length entries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_vld_reg <= '0;
        else if (mem_we)
            len_vld_reg[mem_waddr] <= 1'b1;
    end

    // Window configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= 5'd5;
        else if (cfg_we)
            win_reg <= cfg_wdata;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_ch.valid && in_ch.ready) state_next = ST_READ;
            ST_READ: state_next = ST_EXEC;
            ST_EXEC: state_next = close_req ? ST_TAIL : ST_IDLE;
            ST_TAIL: if (!map_reg[0]) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Main sequencer: the length memory write is issued in the execute cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_WAIT;
            in_ack_reg  <= 1'b0;
            esc_reg     <= 1'b0;
            cur_seq_reg <= '0;
            rx_base_reg <= '0;
            tx_old_reg  <= '0;
            map_reg     <= '0;
            tail_reg    <= '0;
            tx_out_reg  <= '0;
            early_reg   <= '0;
            req_reg     <= '0;
            byte_reg    <= '0;
            rel_reg     <= '0;
            ov_reg      <= 1'b0;
            mem_we      <= 1'b0;
            mem_waddr   <= '0;
            mem_wdata   <= '0;
            o_pw <= 1'b0; o_ovf <= 1'b0; o_ack <= 1'b0; o_txa <= 1'b0;
            o_slot <= '0; o_off <= '0; o_byte <= '0; o_ackseq <= '0; o_txseq <= '0;
        end else begin
            state_reg <= state_next;
            mem_we    <= 1'b0;
            if (ov_reg && out_ch.ready)
                ov_reg <= 1'b0;
            if (state_reg == ST_IDLE && in_ch.valid && in_ch.ready) begin
                req_reg  <= in_ch.req_type;
                byte_reg <= in_ch.rx_byte;
                rel_reg  <= in_ch.release_slot;
            end
            if (state_reg == ST_EXEC) begin
                o_pw <= 1'b0; o_ovf <= 1'b0; o_ack <= 1'b0; o_txa <= 1'b0;
                o_slot <= '0; o_off <= '0; o_byte <= '0; o_ackseq <= '0; o_txseq <= '0;
                // A closing brace holds the result back until the tail walk ends.
                ov_reg <= !close_req;
                if (req_reg == REQ_SENT) begin
                    if (tx_out_reg < eff_win) begin
                        o_txa      <= 1'b1;
                        o_txseq    <= tx_old_reg + 8'(tx_out_reg);
                        tx_out_reg <= tx_out_reg + 5'd1;
                    end
                end else if (req_reg == REQ_RELEASE) begin
                    if (32'(rel_reg) < RX_SLOTS) begin
                        mem_we    <= 1'b1;
                        mem_waddr <= SW'(rel_reg);
                        mem_wdata <= '0;
                    end
                end else if (req_reg == REQ_BYTE) begin
                    priority if (phase_reg == PH_WAIT) begin
                        if (byte_reg == CH_DATA_OPEN || byte_reg == CH_ACK_OPEN) begin
                            phase_reg  <= PH_SEQ;
                            in_ack_reg <= (byte_reg == CH_ACK_OPEN);
                            esc_reg    <= 1'b0;
                        end
                    end else if (phase_reg == PH_SEQ) begin
                        if (in_ack_reg || (byte_reg - rx_base_reg) < 8'(eff_win)) begin
                            cur_seq_reg <= byte_reg;
                            phase_reg   <= PH_BODY;
                        end else begin
                            phase_reg <= PH_WAIT; in_ack_reg <= 1'b0; esc_reg <= 1'b0;
                        end
                    end else if (in_ack_reg) begin
                        if (byte_reg == CH_ACK_CLOSE && tx_out_reg != 5'd0) begin
                            if (cur_seq_reg == tx_old_reg) begin
                                if (6'(early_reg) + 6'd1 > 6'(tx_out_reg)) begin
                                    tx_old_reg <= tx_old_reg + 8'(tx_out_reg);
                                    tx_out_reg <= '0;
                                end else begin
                                    tx_old_reg <= tx_old_reg + 8'(early_reg) + 8'd1;
                                    tx_out_reg <= tx_out_reg - early_reg - 5'd1;
                                end
                                early_reg <= '0;
                            end else if ((cur_seq_reg - tx_old_reg) < 8'(tx_out_reg)) begin
                                if (early_reg < EARLY_MAX)
                                    early_reg <= early_reg + 5'd1;
                            end
                        end
                        phase_reg <= PH_WAIT; in_ack_reg <= 1'b0; esc_reg <= 1'b0;
                    end else if (store_req) begin
                        esc_reg <= 1'b0;
                        o_slot  <= 4'(cur_slot);
                        o_byte  <= byte_reg;
                        if (32'(len_cur) >= SLOT_BYTES) begin
                            o_ovf <= 1'b1;
                        end else begin
                            o_pw      <= 1'b1;
                            o_off     <= 8'(len_cur);
                            mem_we    <= 1'b1;
                            mem_waddr <= cur_slot;
                            mem_wdata <= len_cur + LW'(1);
                        end
                    end else if (esc_reg) begin
                        phase_reg <= PH_WAIT; in_ack_reg <= 1'b0; esc_reg <= 1'b0;
                    end else if (byte_reg == CH_ESC) begin
                        esc_reg <= 1'b1;
                    end else begin
                        // Closing brace: mark the packet and walk the tail.
                        if (cur_gap < 8'd32)
                            map_reg <= map_reg | (MW'(1) << cur_gap[4:0]);
                        phase_reg <= PH_WAIT; in_ack_reg <= 1'b0; esc_reg <= 1'b0;
                        o_ack     <= 1'b1;
                    end
                end
            end
            // Tail advance, one position a cycle; the ack goes out at the end.
            if (state_reg == ST_TAIL) begin
                if (map_reg[0]) begin
                    map_reg     <= map_reg >> 1;
                    rx_base_reg <= rx_base_reg + 8'd1;
                    tail_reg    <= SW'((32'(tail_reg) + 1) % RX_SLOTS);
                end else begin
                    o_ackseq <= rx_base_reg - 8'd1;
                    ov_reg   <= 1'b1;
                end
            end
        end
    end

    assign out_ch.valid          = ov_reg;
    assign out_ch.payload_write  = o_pw;
    assign out_ch.payload_slot   = o_slot;
    assign out_ch.payload_offset = o_off;
    assign out_ch.payload_byte   = o_byte;
    assign out_ch.slot_overflow  = o_ovf;
    assign out_ch.ack_send       = o_ack;
    assign out_ch.ack_seq        = o_ackseq;
    assign out_ch.tx_accepted    = o_txa;
    assign out_ch.tx_seq         = o_txseq;
    assign out_ch.tx_in_flight   = tx_out_reg;
    assign out_ch.tx_base_seq    = tx_old_reg;
    assign out_ch.rx_tail_slot   = 4'(tail_reg);

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the sliding-window link receiver: a queue-fed driver, a monitor,
// and a behavioural predictor of deframing, windows and slot lengths.
// Depends on swlr_pkg, hdl/swlr_if.sv and the unit top level.
`timescale 1ns / 1ps

module tb_top;
    import swlr_pkg::*;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_byte;
        logic [3:0] release_slot;
    } link_item_t;

    typedef struct packed {
        logic       payload_write;
        logic [3:0] payload_slot;
        logic [7:0] payload_offset;
        logic [7:0] payload_byte;
        logic       slot_overflow;
        logic       ack_send;
        logic [7:0] ack_seq;
        logic       tx_accepted;
        logic [7:0] tx_seq;
        logic [4:0] tx_in_flight;
        logic [7:0] tx_base_seq;
        logic [3:0] rx_tail_slot;
    } link_result_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [4:0] cfg_wdata;

    swlr_in_if  in_ch ();
    swlr_out_if out_ch ();

    sliding_window_link_receiver_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Predictor state.
    logic [4:0]  win_reg;
    logic [1:0]  phase;
    logic        ack_mode;
    logic        esc_seen;
    logic [7:0]  cur_seq;
    logic [7:0]  base_seq;
    logic [31:0] rx_map;
    logic [3:0]  tail_idx;
    logic [7:0]  oldest_seq;
    logic [4:0]  in_flight;
    logic [4:0]  early_acks;
    int unsigned slot_len [16];

    link_item_t   pending_items [$];
    link_result_t expected_results [$];
    int           error_count;
    int           result_count;

    // Rough guesses of the sequence bases at queueing time keep packets in window.
    logic [7:0] base_guess;
    logic [7:0] oldest_guess;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int unsigned eff_window();
        return (win_reg > 5'd16) ? 16 : int'(win_reg);
    endfunction

    function automatic void return_to_wait();
        phase    = PH_WAIT;
        ack_mode = 1'b0;
        esc_seen = 1'b0;
    endfunction

    function automatic void store_payload(inout link_result_t r, input logic [7:0] b);
        logic [3:0] slot;
        slot = 4'((8'(cur_seq - base_seq) + tail_idx) % 16);
        r.payload_slot = slot;
        r.payload_byte = b;
        if (slot_len[slot] >= 256)
        begin
            r.slot_overflow = 1'b1;
        end
        else
        begin
            r.payload_write  = 1'b1;
            r.payload_offset = 8'(slot_len[slot]);
            slot_len[slot]++;
        end
    endfunction

    // Closing an ack shrinks the transmit window or counts an early ack.
    function automatic void close_ack(input logic [7:0] b);
        int unsigned n;
        if (b == CH_ACK_CLOSE && in_flight > 0)
        begin
            if (cur_seq == oldest_seq)
            begin
                n = 1 + early_acks;
                if (n > in_flight)
                    n = in_flight;
                oldest_seq = 8'(oldest_seq + n);
                in_flight  = 5'(in_flight - n);
                early_acks = '0;
            end
            else if (8'(cur_seq - oldest_seq) < in_flight)
            begin
                if (early_acks < EARLY_MAX)
                    early_acks++;
            end
        end
        return_to_wait();
    endfunction

    // Closing a data packet marks the bitmap and advances the in-order tail.
    function automatic void close_data(inout link_result_t r);
        logic [7:0] d;
        d = 8'(cur_seq - base_seq);
        if (d < 32)
            rx_map[d[4:0]] = 1'b1;
        while (rx_map[0])
        begin
            rx_map   = rx_map >> 1;
            base_seq = 8'(base_seq + 1);
            tail_idx = 4'(tail_idx + 1);
        end
        r.ack_send = 1'b1;
        r.ack_seq  = 8'(base_seq - 1);
        return_to_wait();
    endfunction

    function automatic void parse_link_byte(inout link_result_t r, input logic [7:0] b);
        if (phase == PH_WAIT)
        begin
            if (b == CH_DATA_OPEN || b == CH_ACK_OPEN)
            begin
                phase    = PH_SEQ;
                ack_mode = (b == CH_ACK_OPEN);
                esc_seen = 1'b0;
            end
        end
        else if (phase == PH_SEQ)
        begin
            if (ack_mode || 8'(b - base_seq) < eff_window())
            begin
                cur_seq = b;
                phase   = PH_BODY;
            end
            else
                return_to_wait();
        end
        else if (ack_mode)
            close_ack(b);
        else if (esc_seen)
        begin
            esc_seen = 1'b0;
            if (b == CH_ESC || b == CH_DATA_CLOSE)
                store_payload(r, b);
            else
                return_to_wait();
        end
        else if (b == CH_ESC)
            esc_seen = 1'b1;
        else if (b == CH_DATA_CLOSE)
            close_data(r);
        else
            store_payload(r, b);
    endfunction

    function automatic link_result_t predict_link_step(input link_item_t it);
        link_result_t r;
        r = '0;
        if (it.req_type == REQ_BYTE)
            parse_link_byte(r, it.rx_byte);
        else if (it.req_type == REQ_SENT)
        begin
            if (in_flight < eff_window())
            begin
                r.tx_accepted = 1'b1;
                r.tx_seq      = 8'(oldest_seq + in_flight);
                in_flight++;
            end
        end
        else if (it.req_type == REQ_RELEASE)
            slot_len[it.release_slot] = 0;
        r.tx_in_flight = in_flight;
        r.tx_base_seq  = oldest_seq;
        r.rx_tail_slot = tail_idx;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch %s: got %0d expected %0d (result %0d)",
                 what, got, want, result_count);
        error_count++;
    endtask

    // Driver: presents queued items, with a random gap after each accepted one.
    int unsigned send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid        <= 1'b0;
            in_ch.req_type     <= '0;
            in_ch.rx_byte      <= '0;
            in_ch.release_slot <= '0;
            send_gap           = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_results.push_back(predict_link_step(
                    {in_ch.req_type, in_ch.rx_byte, in_ch.release_slot}));
                send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (send_gap > 0 || pending_items.size() == 0)
                begin
                    in_ch.valid <= 1'b0;
                    if (send_gap > 0)
                        send_gap--;
                end
                else
                begin
                    link_item_t it;
                    it = pending_items.pop_front();
                    in_ch.valid        <= 1'b1;
                    in_ch.req_type     <= it.req_type;
                    in_ch.rx_byte      <= it.rx_byte;
                    in_ch.release_slot <= it.release_slot;
                end
            end
        end
    end

    // Monitor: checks each accepted result and stalls the ready at random.
    int unsigned sink_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            sink_gap     = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                link_result_t w;
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result", 8'd1, 8'd0);
                end
                else
                begin
                    w = expected_results.pop_front();
                    if (out_ch.payload_write !== w.payload_write)
                        report_mismatch("payload_write", out_ch.payload_write, w.payload_write);
                    if (out_ch.payload_slot !== w.payload_slot)
                        report_mismatch("payload_slot", out_ch.payload_slot, w.payload_slot);
                    if (out_ch.payload_offset !== w.payload_offset)
                        report_mismatch("payload_offset", out_ch.payload_offset,
                                        w.payload_offset);
                    if (out_ch.payload_byte !== w.payload_byte)
                        report_mismatch("payload_byte", out_ch.payload_byte, w.payload_byte);
                    if (out_ch.slot_overflow !== w.slot_overflow)
                        report_mismatch("slot_overflow", out_ch.slot_overflow, w.slot_overflow);
                    if (out_ch.ack_send !== w.ack_send)
                        report_mismatch("ack_send", out_ch.ack_send, w.ack_send);
                    if (out_ch.ack_seq !== w.ack_seq)
                        report_mismatch("ack_seq", out_ch.ack_seq, w.ack_seq);
                    if (out_ch.tx_accepted !== w.tx_accepted)
                        report_mismatch("tx_accepted", out_ch.tx_accepted, w.tx_accepted);
                    if (out_ch.tx_seq !== w.tx_seq)
                        report_mismatch("tx_seq", out_ch.tx_seq, w.tx_seq);
                    if (out_ch.tx_in_flight !== w.tx_in_flight)
                        report_mismatch("tx_in_flight", out_ch.tx_in_flight, w.tx_in_flight);
                    if (out_ch.tx_base_seq !== w.tx_base_seq)
                        report_mismatch("tx_base_seq", out_ch.tx_base_seq, w.tx_base_seq);
                    if (out_ch.rx_tail_slot !== w.rx_tail_slot)
                        report_mismatch("rx_tail_slot", out_ch.rx_tail_slot, w.rx_tail_slot);
                end
                result_count++;
                sink_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
            end
            if (sink_gap > 0)
            begin
                out_ch.ready <= 1'b0;
                sink_gap--;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Run limit.
    int unsigned cycle_count;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 600000)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic queue_item(input logic [1:0] rt, input logic [7:0] b, input logic [3:0] rs);
        pending_items.push_back({rt, b, rs});
    endtask

    // One framed data packet with random body, sometimes escaped.
    task automatic queue_data_packet(input logic [7:0] seq, input int unsigned len);
        logic [7:0] b;
        queue_item(REQ_BYTE, CH_DATA_OPEN, 4'($urandom));
        queue_item(REQ_BYTE, seq, 4'($urandom));
        for (int i = 0; i < len; i++)
        begin
            b = 8'($urandom);
            if (b == CH_ESC || b == CH_DATA_CLOSE || $urandom_range(0, 9) == 0)
            begin
                queue_item(REQ_BYTE, CH_ESC, 4'($urandom));
                b = $urandom_range(0, 1) ? CH_ESC : CH_DATA_CLOSE;
            end
            queue_item(REQ_BYTE, b, 4'($urandom));
        end
        queue_item(REQ_BYTE, CH_DATA_CLOSE, 4'($urandom));
    endtask

    task automatic queue_ack(input logic [7:0] seq, input logic [7:0] close_ch);
        queue_item(REQ_BYTE, CH_ACK_OPEN, 4'($urandom));
        queue_item(REQ_BYTE, seq, 4'($urandom));
        queue_item(REQ_BYTE, close_ch, 4'($urandom));
    endtask

    // Waits until every queued item has gone and every result has come.
    task automatic drain_block();
        while (pending_items.size() != 0 || expected_results.size() != 0 || in_ch.valid)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_window(input logic [4:0] w);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        win_reg = w;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random traffic: data packets near the window, acks, sends and releases, plus noise.
    task automatic queue_random_traffic(input int unsigned n_items);
        int unsigned start;
        int unsigned pick;
        start = pending_items.size();
        while (pending_items.size() - start < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                queue_data_packet(8'(base_guess + $urandom_range(0, 17)),
                                  $urandom_range(0, 9) == 0 ? $urandom_range(0, 40)
                                                            : $urandom_range(0, 5));
            else if (pick < 60)
                queue_ack(8'(oldest_guess + $urandom_range(0, 5)),
                          $urandom_range(0, 7) == 0 ? 8'($urandom) : CH_ACK_CLOSE);
            else if (pick < 75)
                queue_item(REQ_SENT, 8'($urandom), 4'($urandom));
            else if (pick < 82)
                queue_item(REQ_RELEASE, 8'($urandom), 4'($urandom));
            else if (pick < 86)
                queue_item(2'd3, 8'($urandom), 4'($urandom));
            else
                queue_item(REQ_BYTE, 8'($urandom), 4'($urandom));
        end
    endtask

    initial
    begin
        logic [4:0] phase_windows [6];
        phase_windows = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd8, 5'd3};
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        error_count  = 0;
        result_count = 0;
        cycle_count  = 0;
        win_reg    = 5'd5;
        phase      = PH_WAIT;
        ack_mode   = 1'b0;
        esc_seen   = 1'b0;
        cur_seq    = '0;
        base_seq   = '0;
        rx_map     = '0;
        tail_idx   = '0;
        oldest_seq = '0;
        in_flight  = '0;
        early_acks = '0;
        foreach (slot_len[i])
            slot_len[i] = 0;
        base_guess   = '0;
        oldest_guess = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset window: sends, acks, escapes, strays, edge bytes.
        queue_item(REQ_BYTE, 8'hFF, 4'hF);
        queue_item(REQ_BYTE, 8'h00, 4'h0);
        queue_item(REQ_SENT, 8'h00, 4'h0);
        queue_item(REQ_SENT, 8'h00, 4'h0);
        queue_ack(8'd1, CH_ACK_CLOSE);
        queue_ack(8'd0, CH_ACK_CLOSE);
        queue_ack(8'd7, CH_ACK_CLOSE);
        queue_item(REQ_BYTE, CH_DATA_OPEN, 4'h0);
        queue_item(REQ_BYTE, 8'd1, 4'h0);
        queue_item(REQ_BYTE, CH_ESC, 4'h0);
        queue_item(REQ_BYTE, CH_DATA_CLOSE, 4'h0);
        queue_item(REQ_BYTE, CH_DATA_CLOSE, 4'h0);
        queue_data_packet(8'd0, 2);
        queue_data_packet(8'd200, 1);
        queue_item(REQ_BYTE, CH_DATA_OPEN, 4'h0);
        queue_item(REQ_BYTE, 8'd2, 4'h0);
        queue_item(REQ_BYTE, CH_ESC, 4'h0);
        queue_item(REQ_BYTE, 8'h41, 4'h0);
        queue_item(REQ_RELEASE, 8'h00, 4'hF);
        queue_item(2'd3, 8'hFF, 4'hF);
        drain_block();

        // Fill one slot past its size to reach the overflow flag, then release it.
        write_window(5'd16);
        base_guess = base_seq;
        queue_data_packet(base_guess, 270);
        queue_item(REQ_RELEASE, 8'h00, 4'(tail_idx));
        drain_block();

        for (int p = 0; p < 6; p++)
        begin
            write_window(phase_windows[p]);
            for (int k = 0; k < 6; k++)
            begin
                base_guess   = base_seq;
                oldest_guess = oldest_seq;
                queue_random_traffic(45);
                // Hold the sender until the block has caught up once per batch.
                drain_block();
            end
        end

        drain_block();
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== sliding_window_link_receiver_unit.f =====
hdl/swlr_pkg.sv
hdl/swlr_if.sv
hdl/sliding_window_link_receiver_unit.sv
verif/tb_top.sv
